FILE: rtl/gne_pkg.sv
// Shared types and constants for the grid node edge index block.
// Used by gne_edge_unit, grid_node_edge_index and the testbench.
package gne_pkg;

    localparam int RS_W       = 11;
    localparam int CS_W       = 11;
    localparam int DS_W       = 9;
    localparam int NB_W       = 4;
    localparam int EDGE_W     = 31;
    localparam int SLICE_W    = RS_W + CS_W;
    localparam int Z_W        = DS_W;
    localparam int Y_W        = CS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic [NB_W-1:0] t_nb;

    // neighbor codes
    localparam t_nb NB_RIGHT   = 4'd1;
    localparam t_nb NB_DOWN    = 4'd2;
    localparam t_nb NB_LEFT    = 4'd3;
    localparam t_nb NB_UP      = 4'd4;
    localparam t_nb NB_PREV    = 4'd5;
    localparam t_nb NB_NEXT    = 4'd6;
    localparam t_nb NB_DIAG_DL = 4'd7;
    localparam t_nb NB_DIAG_DR = 4'd8;
    localparam t_nb NB_DIAG_UR = 4'd9;
    localparam t_nb NB_DIAG_UL = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SLICES = 2'd2;

    // payload carried along the in-slice divider chain
    typedef struct packed {
        t_nb                nb;
        logic [Z_W-1:0]     z;
        logic               in_range;
        logic [SLICE_W-1:0] zp;
    } t_d2_pay;

    // decomposed node handed to the edge unit
    typedef struct packed {
        t_nb                nb;
        logic [Z_W-1:0]     z;
        logic               in_range;
        logic [SLICE_W-1:0] zp;
        logic [Y_W-1:0]     y;
        logic [RS_W-1:0]    x;
    } t_item;

    // volume geometry derived from the configuration
    typedef struct packed {
        logic [RS_W-1:0]   rs;
        logic [CS_W-1:0]   cs;
        logic [DS_W-1:0]   ds;
        logic [EDGE_W-1:0] slice;
        logic [EDGE_W-1:0] v;
        logic [EDGE_W-1:0] vh;
        logic [EDGE_W-1:0] blk;
        logic [EDGE_W-1:0] diag;
    } t_geom;

    typedef struct packed {
        logic              valid_res;
        logic [EDGE_W-1:0] edge_index;
    } t_result;

endpackage

FILE: rtl/gne_div_cell.sv
// One restoring-division cell: resolves one quotient bit and registers it.
// Cells are chained to form a pipelined divider. No package dependency.
module gne_div_cell #(
    parameter int DW  = 28,
    parameter int DVW = 22,
    parameter int QW  = 9,
    parameter int SH  = 0,
    parameter int PW  = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [DW-1:0]  i_rem,
    input  logic [QW-1:0]  i_quot,
    input  logic [DVW-1:0] i_divisor,
    input  logic [PW-1:0]  i_payload,
    output logic           o_valid,
    output logic [DW-1:0]  o_rem,
    output logic [QW-1:0]  o_quot,
    output logic [PW-1:0]  o_payload
);

    localparam int TW = (DW > DVW + SH) ? DW : DVW + SH;

    logic [TW-1:0] rem_ext;
    logic [TW-1:0] trial;
    logic [TW-1:0] diff;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_quot;

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quot;
    logic [PW-1:0] r_payload;

    always_comb begin
        rem_ext = TW'(i_rem);
        trial   = TW'(i_divisor) << SH;
        diff    = rem_ext - trial;
        ge      = (rem_ext >= trial);
        n_rem   = ge ? diff[DW-1:0] : i_rem;
        n_quot  = ge ? (i_quot | (QW'(1) << SH)) : i_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem     <= n_rem;
            r_quot    <= n_quot;
            r_payload <= i_payload;
        end
    end

    assign o_valid   = r_valid;
    assign o_rem     = r_rem;
    assign o_quot    = r_quot;
    assign o_payload = r_payload;

endmodule

FILE: rtl/gne_edge_unit.sv
// Edge unit: existence test, slice products, then the edge index sum.
// Depends on gne_pkg (t_item, t_geom, t_result, neighbor codes).
module gne_edge_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  gne_pkg::t_item   i_item,
    input  gne_pkg::t_geom   i_geom,
    output logic             o_valid,
    output gne_pkg::t_result o_res
);
    import gne_pkg::*;

    logic [RS_W:0] x_p1;
    logic [CS_W:0] y_p1;
    logic [DS_W:0] z_p1;
    logic          x_right;
    logic          y_down;
    logic          z_next;
    logic          ok_nb;
    logic          n_ok;

    logic              r_valid;
    logic              r_ok;
    t_nb               r_nb;
    logic [EDGE_W-1:0] r_zp;
    logic [EDGE_W-1:0] r_y;
    logic [EDGE_W-1:0] r_p_blk;
    logic [EDGE_W-1:0] r_p_vh;
    logic [EDGE_W-1:0] r_p_sl;

    logic [EDGE_W-1:0] rs_e;
    logic [EDGE_W-1:0] base;
    logic [EDGE_W-1:0] nxt_t;
    logic [EDGE_W-1:0] e_val;

    // stage A: neighbor existence
    always_comb begin
        x_p1    = {1'b0, i_item.x} + {{RS_W{1'b0}}, 1'b1};
        y_p1    = {1'b0, i_item.y} + {{CS_W{1'b0}}, 1'b1};
        z_p1    = {1'b0, i_item.z} + {{DS_W{1'b0}}, 1'b1};
        x_right = (x_p1 < {1'b0, i_geom.rs});
        y_down  = (y_p1 < {1'b0, i_geom.cs});
        z_next  = (z_p1 < {1'b0, i_geom.ds});
        case (i_item.nb)
            NB_RIGHT:   ok_nb = x_right;
            NB_DOWN:    ok_nb = y_down;
            NB_LEFT:    ok_nb = (i_item.x != '0);
            NB_UP:      ok_nb = (i_item.y != '0);
            NB_PREV:    ok_nb = (i_item.z != '0);
            NB_NEXT:    ok_nb = z_next;
            NB_DIAG_DL: ok_nb = (i_item.x != '0) && (i_item.y != '0);
            NB_DIAG_DR: ok_nb = y_down && x_right;
            NB_DIAG_UR: ok_nb = (i_item.x != '0) && y_down;
            NB_DIAG_UL: ok_nb = (i_item.y != '0) && x_right;
            default:    ok_nb = 1'b0;
        endcase
        n_ok = i_item.in_range && ok_nb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok    <= n_ok;
            r_nb    <= i_item.nb;
            r_zp    <= EDGE_W'(i_item.zp);
            r_y     <= EDGE_W'(i_item.y);
            r_p_blk <= EDGE_W'(i_item.z) * i_geom.blk;
            r_p_vh  <= EDGE_W'(i_item.z) * i_geom.vh;
            r_p_sl  <= EDGE_W'(i_item.z) * i_geom.slice;
        end
    end

    // stage B: edge index, all sums modulo 2^EDGE_W
    always_comb begin
        rs_e  = EDGE_W'(i_geom.rs);
        base  = r_zp + r_p_blk;
        nxt_t = base + i_geom.blk - r_y;
        case (r_nb)
            NB_RIGHT:   e_val = base + i_geom.v - r_y;
            NB_DOWN:    e_val = base;
            NB_LEFT:    e_val = base + i_geom.v - r_y - EDGE_W'(1);
            NB_UP:      e_val = base - rs_e;
            NB_PREV:    e_val = r_p_vh + r_zp + r_p_sl - i_geom.slice;
            NB_NEXT:    e_val = r_p_vh + i_geom.vh + r_zp + r_p_sl;
            NB_DIAG_DL: e_val = nxt_t - rs_e;
            NB_DIAG_DR: e_val = nxt_t;
            NB_DIAG_UR: e_val = nxt_t + i_geom.diag - EDGE_W'(1);
            NB_DIAG_UL: e_val = nxt_t - rs_e + i_geom.diag + EDGE_W'(1);
            default:    e_val = '0;
        endcase
    end

    assign o_valid          = r_valid;
    assign o_res.valid_res  = r_ok;
    assign o_res.edge_index = r_ok ? e_val : '0;

endmodule

FILE: rtl/grid_node_edge_index.sv
// Grid node edge index: maps a voxel index and a neighbor number to the
// index of the joining edge in a row x column x depth grid graph.
// Usage:
//   Input channel  i_valid / o_stall carries i_node_index and
//   i_neighbor_number; an item is taken when i_valid is high and o_stall low.
//   Output channel o_valid / i_stall carries o_valid_res and o_edge_index.
//   One result leaves for every item, in order.
//   Configuration: write i_cfg_data to register i_cfg_index (0 row size,
//   1 column size, 2 depth) with i_cfg_we, only while no item is in flight.
// One item per cycle is taken back to back while o_stall is low: an input
// register feeds a 9-cell divider chain that splits off the slice, an 11-cell
// chain splits row and column, and a two-stage edge unit forms the index.
// Reset sets the registers to 256 x 256 x 1 and empties the pipeline.
// When the receiver stalls, one more item lands in a skid register; then
// o_stall rises and the whole pipeline holds until the skid drains.
module grid_node_edge_index #(
    parameter int NODE_INDEX_WIDTH = 28
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [NODE_INDEX_WIDTH-1:0]       i_node_index,
    input  logic [gne_pkg::NB_W-1:0]          i_neighbor_number,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_valid_res,
    output logic [gne_pkg::EDGE_W-1:0]        o_edge_index,
    input  logic                              i_cfg_we,
    input  logic [gne_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gne_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gne_pkg::*;

    localparam int NW  = NODE_INDEX_WIDTH;
    localparam int MW  = (NW > SLICE_W) ? NW : SLICE_W;
    localparam int PW2 = $bits(t_d2_pay);

    // configuration and derived geometry
    logic [RS_W-1:0]    r_rs;
    logic [CS_W-1:0]    r_cs;
    logic [DS_W-1:0]    r_ds;
    logic [SLICE_W-1:0] r_slice;
    logic [SLICE_W-1:0] r_v;
    logic [SLICE_W-1:0] r_h;
    logic [SLICE_W-1:0] r_diag;
    logic [EDGE_W-1:0]  r_vh;
    logic [EDGE_W-1:0]  r_blk;
    logic [RS_W-1:0]    rs_m1;
    logic [CS_W-1:0]    cs_m1;
    logic [EDGE_W-1:0]  n_vh;
    t_geom              geom;

    // pipeline control
    logic    en;
    logic    take;
    logic    r_in_valid;
    logic [NW-1:0] r_node;
    t_nb     r_nb;

    // divider chains
    logic               d1_valid [0:Z_W];
    logic [NW-1:0]      d1_rem   [0:Z_W];
    logic [Z_W-1:0]     d1_quot  [0:Z_W];
    logic [NB_W-1:0]    d1_pay   [0:Z_W];
    logic               d2_valid [0:Y_W];
    logic [SLICE_W-1:0] d2_rem   [0:Y_W];
    logic [Y_W-1:0]     d2_quot  [0:Y_W];
    logic [PW2-1:0]     d2_pay   [0:Y_W];

    logic [MW-1:0] slice_rem;
    logic [MW-1:0] slice_div;
    t_d2_pay       mid_pay;
    t_d2_pay       end_pay;
    t_item         item;

    logic    eu_valid;
    t_result eu_res;

    logic    r_o_valid;
    t_result r_o_res;
    logic    r_skid_valid;
    t_result r_skid_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs <= RS_W'(256);
            r_cs <= CS_W'(256);
            r_ds <= DS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_SIZE:     r_rs <= i_cfg_data[RS_W-1:0];
                CFG_COL_SIZE:     r_cs <= i_cfg_data[CS_W-1:0];
                CFG_DEPTH_SLICES: r_ds <= i_cfg_data[DS_W-1:0];
                default:          ;
            endcase
        end
    end

    // a zero size only wraps the derived terms; such a volume never
    // yields a valid edge
    always_comb begin
        rs_m1 = r_rs - RS_W'(1);
        cs_m1 = r_cs - CS_W'(1);
        n_vh  = EDGE_W'(r_v) + EDGE_W'(r_h);
    end

    always_ff @(posedge i_clk) begin
        r_slice <= SLICE_W'(r_rs) * SLICE_W'(r_cs);
        r_v     <= SLICE_W'(cs_m1) * SLICE_W'(r_rs);
        r_h     <= SLICE_W'(rs_m1) * SLICE_W'(r_cs);
        r_diag  <= SLICE_W'(rs_m1) * SLICE_W'(cs_m1);
        r_vh    <= n_vh;
        r_blk   <= n_vh + EDGE_W'(r_slice);
    end

    always_comb begin
        geom.rs    = r_rs;
        geom.cs    = r_cs;
        geom.ds    = r_ds;
        geom.slice = EDGE_W'(r_slice);
        geom.v     = EDGE_W'(r_v);
        geom.vh    = r_vh;
        geom.blk   = r_blk;
        geom.diag  = EDGE_W'(r_diag);
    end

    // whole pipeline holds while the skid register is occupied
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign take    = r_o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_node <= i_node_index;
            r_nb   <= i_neighbor_number;
        end
    end

    // slice divider: node = z * slice + zp
    assign d1_valid[0] = r_in_valid;
    assign d1_rem[0]   = r_node;
    assign d1_quot[0]  = '0;
    assign d1_pay[0]   = r_nb;

    for (genvar gi = 0; gi < Z_W; gi++) begin : g_d1
        gne_div_cell #(
            .DW  (NW),
            .DVW (SLICE_W),
            .QW  (Z_W),
            .SH  (Z_W - 1 - gi),
            .PW  (NB_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (d1_valid[gi]),
            .i_rem     (d1_rem[gi]),
            .i_quot    (d1_quot[gi]),
            .i_divisor (r_slice),
            .i_payload (d1_pay[gi]),
            .o_valid   (d1_valid[gi+1]),
            .o_rem     (d1_rem[gi+1]),
            .o_quot    (d1_quot[gi+1]),
            .o_payload (d1_pay[gi+1])
        );
    end

    // node lies in the volume iff the remainder fits a slice and z < depth
    always_comb begin
        slice_rem        = MW'(d1_rem[Z_W]);
        slice_div        = MW'(r_slice);
        mid_pay.nb       = d1_pay[Z_W];
        mid_pay.z        = d1_quot[Z_W];
        mid_pay.in_range = (slice_rem < slice_div) && (d1_quot[Z_W] < r_ds);
        mid_pay.zp       = slice_rem[SLICE_W-1:0];
    end

    // row divider: zp = y * row_size + x
    assign d2_valid[0] = d1_valid[Z_W];
    assign d2_rem[0]   = mid_pay.zp;
    assign d2_quot[0]  = '0;
    assign d2_pay[0]   = mid_pay;

    for (genvar gj = 0; gj < Y_W; gj++) begin : g_d2
        gne_div_cell #(
            .DW  (SLICE_W),
            .DVW (RS_W),
            .QW  (Y_W),
            .SH  (Y_W - 1 - gj),
            .PW  (PW2)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (d2_valid[gj]),
            .i_rem     (d2_rem[gj]),
            .i_quot    (d2_quot[gj]),
            .i_divisor (r_rs),
            .i_payload (d2_pay[gj]),
            .o_valid   (d2_valid[gj+1]),
            .o_rem     (d2_rem[gj+1]),
            .o_quot    (d2_quot[gj+1]),
            .o_payload (d2_pay[gj+1])
        );
    end

    always_comb begin
        end_pay       = d2_pay[Y_W];
        item.nb       = end_pay.nb;
        item.z        = end_pay.z;
        item.in_range = end_pay.in_range;
        item.zp       = end_pay.zp;
        item.y        = d2_quot[Y_W];
        item.x        = d2_rem[Y_W][RS_W-1:0];
    end

    gne_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d2_valid[Y_W]),
        .i_item  (item),
        .i_geom  (geom),
        .o_valid (eu_valid),
        .o_res   (eu_res)
    );

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_o_valid    <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (eu_valid) begin
            if (!r_o_valid || take) begin
                r_o_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_o_res <= r_skid_res;
            end
        end else if (eu_valid) begin
            if (!r_o_valid || take) begin
                r_o_res <= eu_res;
            end else begin
                r_skid_res <= eu_res;
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_valid_res  = r_o_res.valid_res;
    assign o_edge_index = r_o_res.edge_index;

endmodule

FILE: tb/grid_node_edge_index_tb.sv
// Self-checking testbench for grid_node_edge_index: random and directed voxel queries
// under several volume geometries, checked against an in-bench edge index predictor.
// Depends on gne_pkg and the grid_node_edge_index RTL.
module grid_node_edge_index_tb;
    import gne_pkg::*;

    localparam int NODE_W = 28;

    // holds the expected edge results of accepted queries, oldest first
    class edge_index_board;
        bit [RS_W-1:0] rs;
        bit [CS_W-1:0] cs;
        bit [DS_W-1:0] ds;
        t_result       expected_q[$];
        int unsigned   errors;

        function new();
            rs = 256;
            cs = 256;
            ds = 1;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROW_SIZE:     rs = data[RS_W-1:0];
                CFG_COL_SIZE:     cs = data[CS_W-1:0];
                CFG_DEPTH_SLICES: ds = data[DS_W-1:0];
                default: ;
            endcase
        endfunction

        function t_result edge_of(bit [NODE_W-1:0] node, t_nb nb);
            longint unsigned r, c, d, sl, tot, zp, z, x, y, v, h, blk, nxt, dg, e;
            bit      ok;
            t_result res;
            r = rs;
            c = cs;
            d = ds;
            sl = r * c;
            tot = sl * d;
            ok = 1'b0;
            e = 0;
            if (tot != 0 && node < tot) begin
                zp = node % sl;
                z = node / sl;
                x = zp % r;
                y = zp / r;
                v = (c - 1) * r;
                h = (r - 1) * c;
                blk = v + h + sl;
                nxt = (z + 1) * blk;
                dg = (r - 1) * (c - 1);
                case (nb)
                    NB_RIGHT: if (x < r - 1) begin
                        ok = 1'b1; e = zp + v - y + z * blk;
                    end
                    NB_DOWN: if (y < c - 1) begin
                        ok = 1'b1; e = zp + z * blk;
                    end
                    NB_LEFT: if (x != 0) begin
                        ok = 1'b1; e = zp + v - y - 1 + z * blk;
                    end
                    NB_UP: if (y != 0) begin
                        ok = 1'b1; e = zp - r + z * blk;
                    end
                    NB_PREV: if (z != 0) begin
                        ok = 1'b1; e = z * (v + h) + zp + (z - 1) * sl;
                    end
                    NB_NEXT: if (z + 1 < d) begin
                        ok = 1'b1; e = (z + 1) * (v + h) + zp + z * sl;
                    end
                    // diagonals sit past the slice's own edges, even in the last slice
                    NB_DIAG_DL: if (x != 0 && y != 0) begin
                        ok = 1'b1; e = zp - r + nxt - y;
                    end
                    NB_DIAG_DR: if (y < c - 1 && x < r - 1) begin
                        ok = 1'b1; e = zp + nxt - y;
                    end
                    NB_DIAG_UR: if (x != 0 && y < c - 1) begin
                        ok = 1'b1; e = zp + nxt - y + dg - 1;
                    end
                    NB_DIAG_UL: if (y != 0 && x < r - 1) begin
                        ok = 1'b1; e = zp - r + nxt - y + 1 + dg;
                    end
                    default: ;
                endcase
            end
            res.valid_res = ok;
            res.edge_index = ok ? e[EDGE_W-1:0] : '0;
            return res;
        endfunction

        function void note_query(bit [NODE_W-1:0] node, t_nb nb);
            expected_q.push_back(edge_of(node, nb));
        endfunction

        function void check_result(logic valid_res, logic [EDGE_W-1:0] edge_index);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: valid_res=%0d edge_index=%0d",
                             valid_res, edge_index);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (valid_res !== exp_r.valid_res || edge_index !== exp_r.edge_index) begin
                if (errors < 10)
                    $display("mismatch: expected valid_res=%0d edge_index=%0d, got %0d %0d",
                             exp_r.valid_res, exp_r.edge_index, valid_res, edge_index);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [NODE_W-1:0]     i_node_index = '0;
    logic [NB_W-1:0]       i_neighbor_number = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_valid_res;
    logic [EDGE_W-1:0]     o_edge_index;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    edge_index_board sb = new();
    bit              tx_gaps = 1'b0;
    bit              rx_stalls = 1'b0;
    int unsigned     stall_left = 0;

    grid_node_edge_index #(
        .NODE_INDEX_WIDTH(NODE_W)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_node_index     (i_node_index),
        .i_neighbor_number(i_neighbor_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_valid_res      (o_valid_res),
        .o_edge_index     (o_edge_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver raises i_stall in bursts of random length while rx_stalls is set
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // both channels sampled at the edge, before any update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result(o_valid_res, o_edge_index);
            if (i_valid && !o_stall)
                sb.note_query(i_node_index, i_neighbor_number);
        end
    end

    task automatic send_query(input logic [NODE_W-1:0] node, input t_nb nb);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_node_index <= node;
        i_neighbor_number <= nb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // called only while idle, just after the clock rises
    task automatic write_geometry(input int unsigned r, input int unsigned c,
                                  input int unsigned d);
        logic [CFG_DATA_W-1:0] ddata;
        // bits above the depth field ride along and must be ignored
        ddata = {2'($urandom_range(0, 3)), 9'(d)};
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_ROW_SIZE;
        i_cfg_data <= 11'(r);
        sb.set_reg(CFG_ROW_SIZE, 11'(r));
        @(posedge i_clk);
        i_cfg_index <= CFG_COL_SIZE;
        i_cfg_data <= 11'(c);
        sb.set_reg(CFG_COL_SIZE, 11'(c));
        @(posedge i_clk);
        i_cfg_index <= CFG_DEPTH_SLICES;
        i_cfg_data <= ddata;
        sb.set_reg(CFG_DEPTH_SLICES, ddata);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic longint unsigned pick_coord(longint unsigned n);
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (n == 0) return 0;
        if (sel == 0) return 0;
        if (sel == 1) return n - 1;
        return {$urandom, $urandom} % n;
    endfunction

    // mostly in-volume voxels biased to the borders, some just past the end,
    // some fully random
    task automatic make_query(output logic [NODE_W-1:0] node, output t_nb nb);
        int unsigned     mode, r;
        longint unsigned rsz, csz, dsz, tot, x, y, z;
        rsz = sb.rs;
        csz = sb.cs;
        dsz = sb.ds;
        tot = rsz * csz * dsz;
        r = $urandom_range(0, 19);
        if (r < 17) nb = t_nb'($urandom_range(NB_RIGHT, NB_DIAG_UL));
        else if (r == 17) nb = '0;
        else nb = t_nb'($urandom_range(11, 15));
        mode = $urandom_range(0, 9);
        if (mode == 0 || tot == 0) begin
            node = NODE_W'($urandom);
        end else if (mode == 1) begin
            node = NODE_W'(tot + $urandom_range(0, 3));
        end else begin
            x = pick_coord(rsz);
            y = pick_coord(csz);
            z = pick_coord(dsz);
            node = NODE_W'(x + rsz * y + rsz * csz * z);
        end
    endtask

    initial begin
        int unsigned     p_rs[] = '{2, 1024, 3, 2, 1024, 1, 5, 0, 4, 2047};
        int unsigned     p_cs[] = '{2, 1024, 5, 1024, 2, 4, 1, 8, 4, 2047};
        int unsigned     p_ds[] = '{1, 256, 4, 2, 3, 3, 2, 2, 0, 511};
        int unsigned     p_n[]  = '{30, 60, 60, 30, 30, 20, 20, 10, 10, 30};
        logic [NODE_W-1:0] node;
        t_nb               nb;
        int unsigned       r, c, d;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry 256 x 256 x 1: every neighbor code at the first voxel
        // (diagonals reach past the only slice), corners, out-of-volume nodes
        for (int k = 0; k < 16; k++)
            send_query('0, t_nb'(k));
        send_query(NODE_W'(65535), NB_RIGHT);
        send_query(NODE_W'(65535), NB_DOWN);
        send_query(NODE_W'(65535), NB_LEFT);
        send_query(NODE_W'(65535), NB_UP);
        send_query(NODE_W'(65536), NB_RIGHT);
        send_query('1, NB_DOWN);
        send_query(NODE_W'(257), NB_NEXT);
        send_query(NODE_W'(257), NB_PREV);
        i_valid <= 1'b0;
        wait_idle();

        // fixed geometries: range extremes, unit row and column, empty volumes,
        // then every field at its widest
        for (int p = 0; p < p_rs.size(); p++) begin
            write_geometry(p_rs[p], p_cs[p], p_ds[p]);
            tx_gaps = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            for (int i = 0; i < p_n[p]; i++) begin
                if (p == 2 && i == 30) begin
                    i_valid <= 1'b0;
                    wait_idle();
                end
                make_query(node, nb);
                send_query(node, nb);
            end
            i_valid <= 1'b0;
            wait_idle();
        end

        // random in-range geometries, mostly small; the last one without idling
        for (int p = 0; p < 5; p++) begin
            r = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 1024) : $urandom_range(2, 24);
            c = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 1024) : $urandom_range(2, 24);
            d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 8);
            write_geometry(r, c, d);
            tx_gaps = (p < 4) && ($urandom_range(0, 3) != 0);
            rx_stalls = (p < 4) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < ((p < 4) ? 40 : 60); i++) begin
                make_query(node, nb);
                send_query(node, nb);
            end
            i_valid <= 1'b0;
            if (p < 4) wait_idle();
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/gne_pkg.sv
rtl/gne_div_cell.sv
rtl/gne_edge_unit.sv
rtl/grid_node_edge_index.sv
tb/grid_node_edge_index_tb.sv
